[src/postorder_subtree_size_stack_top_assert.svh]
// Assertion macros for the subtree size stack.
`ifndef POSTORDER_SUBTREE_SIZE_STACK_TOP_ASSERT_SVH
`define POSTORDER_SUBTREE_SIZE_STACK_TOP_ASSERT_SVH

// Check a property outside of reset.
`define PSS_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/pss_pkg.sv]
package pss_pkg;

   localparam int KIND_W   = 8;
   localparam int SIZE_W   = 17;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 3;

   localparam int unsigned SIZE_FIELD_MAX = (1 << SIZE_W) - 1;
   localparam int unsigned COUNT_MAX      = (1 << COUNT_W) - 1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FEW      = 3'd1,
      STAT_WRONG    = 3'd2,
      STAT_MISSING  = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind_code;
      logic               fixed_count;
      logic [COUNT_W-1:0] child_total;
      logic               check_bracket;
      logic [KIND_W-1:0]  bracket_kind;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] tree_size;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

   typedef struct packed {
      shift_type shift;
      entry_type entry;
   } stack_cmd_type;

endpackage

[src/pss_cell.sv]
module pss_cell
   import pss_pkg::*;
(
   input  logic      clock,
   input  shift_type shift,
   input  entry_type from_above,
   input  entry_type from_below,
   output entry_type held
);

   entry_type held_ff;
   entry_type held_in;

   always_comb begin
      held_in = held_ff;
      priority if (shift.push) begin
         held_in = from_above;
      end else if (shift.pop) begin
         held_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   assign held = held_ff;

endmodule

[src/pss_stack.sv]
module pss_stack
   import pss_pkg::*;
#(
   parameter int STACK_DEPTH = 256
) (
   input  logic          clock,
   input  stack_cmd_type cmd,
   output entry_type     top
);

   entry_type chain [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      entry_type above;
      entry_type below;

      if (i == 0) begin : g_head
         assign above = cmd.entry;
      end else begin : g_body
         assign above = chain[i-1];
      end

      // the deepest cell refills from itself on a pop
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign below = chain[i];
      end else begin : g_inner
         assign below = chain[i+1];
      end

      pss_cell u_cell (
         .clock      (clock),
         .shift      (cmd.shift),
         .from_above (above),
         .from_below (below),
         .held       (chain[i])
      );
   end

   assign top = chain[0];

endmodule

[src/pss_ctrl.sv]
module pss_ctrl
   import pss_pkg::*;
#(
   parameter int STACK_DEPTH    = 256,
   parameter int MAX_CHILDREN   = 15,
   parameter int MAX_TREE_NODES = 65536
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   output stack_cmd_type cmd,
   input  entry_type     top
);

   localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
   localparam logic [LEVEL_W-1:0] LevelFull = LEVEL_W'(STACK_DEPTH);
   localparam int unsigned CapInt =
      (MAX_TREE_NODES < SIZE_FIELD_MAX) ? MAX_TREE_NODES : SIZE_FIELD_MAX;
   localparam logic [SIZE_W:0] SizeCap = (SIZE_W+1)'(CapInt);
   localparam int unsigned ChildCapInt =
      (MAX_CHILDREN < COUNT_MAX) ? MAX_CHILDREN : COUNT_MAX;
   localparam logic [COUNT_W-1:0] ChildCap = COUNT_W'(ChildCapInt);

   typedef enum logic [1:0] {
      CTRL_IDLE = 2'b01,
      CTRL_WALK = 2'b10
   } ctrl_state_type;

   ctrl_state_type     state_ff, state_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               rsp_valid_ff, rsp_valid_in;

   req_type            item_ff, item_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic [KIND_W-1:0]  last_kind_ff, last_kind_in;
   logic               popped_ff, popped_in;
   logic               found_ff, found_in;
   rsp_type            rsp_ff, rsp_in;

   logic              accept;
   logic              out_free;
   logic              empty;
   logic              done;
   logic [SIZE_W:0]   sum;
   logic [SIZE_W-1:0] sum_sat;
   status_type        status;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign empty    = (level_ff == LEVEL_W'(0));
   assign done     = item_ff.fixed_count ? (remain_ff == COUNT_W'(0) || empty)
                                         : (found_ff || empty);

   assign sum     = {1'b0, size_ff} + {1'b0, top.size};
   assign sum_sat = (sum > SizeCap) ? SizeCap[SIZE_W-1:0] : sum[SIZE_W-1:0];

   always_comb begin
      if (level_ff == LevelFull) begin
         status = STAT_OVERFLOW;
      end else if (item_ff.fixed_count) begin
         if (remain_ff != COUNT_W'(0)) begin
            status = STAT_FEW;
         end else if (item_ff.check_bracket && popped_ff &&
                      last_kind_ff != item_ff.bracket_kind) begin
            status = STAT_WRONG;
         end else begin
            status = STAT_OK;
         end
      end else begin
         status = found_ff ? STAT_OK : STAT_MISSING;
      end
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      item_in      = item_ff;
      size_in      = size_ff;
      remain_in    = remain_ff;
      last_kind_in = last_kind_ff;
      popped_in    = popped_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      cmd.shift    = '0;
      cmd.entry    = '{kind: item_ff.kind_code, size: size_ff};

      unique case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               item_in   = req_data;
               size_in   = SIZE_W'(1);
               remain_in = (req_data.child_total > ChildCap) ? ChildCap
                                                             : req_data.child_total;
               popped_in = 1'b0;
               found_in  = 1'b0;
               state_in  = CTRL_WALK;
            end
         end
         CTRL_WALK: begin
            if (!done) begin
               // pop one child and fold in its size
               cmd.shift.pop = 1'b1;
               size_in       = sum_sat;
               level_in      = level_ff - LEVEL_W'(1);
               remain_in     = remain_ff - COUNT_W'(1);
               last_kind_in  = top.kind;
               popped_in     = 1'b1;
               found_in      = (top.kind == item_ff.bracket_kind);
            end else if (out_free) begin
               // push unless full, then hand the beat to the output register
               if (level_ff != LevelFull) begin
                  cmd.shift.push = 1'b1;
                  level_in       = level_ff + LEVEL_W'(1);
               end
               rsp_in       = '{tree_size: size_ff, status: status};
               rsp_valid_in = 1'b1;
               state_in     = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      size_ff      <= size_in;
      remain_ff    <= remain_in;
      last_kind_ff <= last_kind_in;
      popped_ff    <= popped_in;
      found_ff     <= found_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != CTRL_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/postorder_subtree_size_stack_top.sv]
// Channel  Direction  Ports                          Beat
// req      in         req_valid req_stall req_data   one postorder node
// rsp      out        rsp_valid rsp_stall rsp_data   subtree size and status
//
// A node is accepted, then pops its entries one by one through the shift chain
// of STACK_DEPTH cells, and then pushes its own entry.
// Reset clears the stack level and the handshakes; cell contents stay undefined.
// A stalled result holds in the output register; the next node is accepted
// meanwhile, and its push waits until that register is free.
module postorder_subtree_size_stack_top
   import pss_pkg::*;
#(
   parameter int STACK_DEPTH    = 256,
   parameter int MAX_CHILDREN   = 15,
   parameter int MAX_TREE_NODES = 65536
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   stack_cmd_type cmd;
   entry_type     top;

   pss_ctrl #(
      .STACK_DEPTH    (STACK_DEPTH),
      .MAX_CHILDREN   (MAX_CHILDREN),
      .MAX_TREE_NODES (MAX_TREE_NODES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .top       (top)
   );

   pss_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .cmd   (cmd),
      .top   (top)
   );

endmodule

[src/pss_checker.sv]
`include "postorder_subtree_size_stack_top_assert.svh"

module pss_checker
   import pss_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_beat;
   logic rsp_waiting;
   logic rsp_fields_ok;

   assign req_beat      = req_valid && !req_stall;
   assign rsp_waiting   = rsp_valid && rsp_stall;
   assign rsp_fields_ok = (rsp_data.tree_size != '0) && (rsp_data.status <= STAT_OVERFLOW);

   `PSS_ASSERT_RUN(a_rsp_hold, clock, reset,
      rsp_waiting |=> rsp_valid && $stable(rsp_data), "stalled result changed")
   `PSS_ASSERT_RUN(a_busy_after_req, clock, reset,
      req_beat |=> req_stall, "node accepted while another is in work")
   `PSS_ASSERT_RUN(a_rsp_sane, clock, reset,
      rsp_valid |-> rsp_fields_ok, "bad result fields")
   `PSS_ASSERT_ALWAYS(a_reset_quiet, clock,
      $past(reset) |-> !rsp_valid, "result shown right after reset")

endmodule

bind postorder_subtree_size_stack_top pss_checker u_pss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
